// ===== hdl/wah_pkg.sv =====
// Shared types and constants for the windowed autorange unit.
`default_nettype none
package wah_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 13;
  localparam int OUT_W    = 17;

  // Reciprocal of ten: floor(x * RECIP10 / 2**RECIP_SHIFT) equals x / 10 for any 16-bit x.
  localparam int RECIP10     = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 32;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [CFG_W-1:0]        HALF_RESET  = 13'd180;
  localparam logic signed [OUT_W-1:0] SHOWN_LO_RST = -17'sd200;
  localparam logic signed [OUT_W-1:0] SHOWN_HI_RST = 17'sd200;
  localparam logic signed [OUT_W+1:0] OUT_MIN      = -19'sd65536;
  localparam logic signed [OUT_W+1:0] OUT_MAX      = 19'sd65535;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic write;
    logic scan_start;
    logic scan_rd;
    logic calc_mid;
    logic div_span;
    logic calc_pad;
    logic div_prev;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/wah_sample_if.sv =====
// Input channel carrying one sample triple per item.
`default_nettype none
interface wah_sample_if import wah_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic signed [SAMPLE_W-1:0] sample_c;

  modport source(output valid, output sample_a, output sample_b, output sample_c,
                 input ready);
  modport sink(input valid, input sample_a, input sample_b, input sample_c,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/wah_range_if.sv =====
// Output channel carrying one display range result per item.
`default_nettype none
interface wah_range_if import wah_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] range_low;
  logic signed [OUT_W-1:0] range_high;
  logic                    range_moved;

  modport source(output valid, output range_low, output range_high, output range_moved,
                 input ready);
  modport sink(input valid, input range_low, input range_high, input range_moved,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/window_autorange_hysteresis_unit.sv =====
// Top level of the windowed autorange unit with hysteresis.
//
// Each accepted item (three signed 16-bit samples) is written into a window of the last
// WINDOW_DEPTH triples, the filled slots are scanned for the smallest and largest sample,
// and a padded display range is derived; the stored range moves only when a bound changes
// by more than one twentieth of the stored span. For an item the unit writes the window, the
// scan reads one slot per cycle from the single-port window memory over the N filled slots
// (the new one included), a drain step takes the last read, and the range arithmetic shares
// one reciprocal multiplier over five further steps. The unit is ready for the next item once the
// result sits in the output register, even if it has not been taken yet; a result still
// waiting in the output register holds back the final step of the following item until
// it is taken. The half-span floor register is written through cfg_we and cfg_data; the
// user must write it only while the unit is idle, as the unit itself does not enforce
// this. It resets to 180, and the stored range resets to -200 .. 200 with the window
// empty.
`default_nettype none
module window_autorange_hysteresis_unit import wah_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  wah_sample_if.sink            samples,
  wah_range_if.source           ranges
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  wah_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath.
  wah_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sample_a  (samples.sample_a),
    .sample_b  (samples.sample_b),
    .sample_c  (samples.sample_c),
    .cmd       (cmd),
    .status    (status),
    .out_ready (ranges.ready),
    .out_valid (ranges.valid),
    .out_low   (ranges.range_low),
    .out_high  (ranges.range_high),
    .out_moved (ranges.range_moved)
  );

endmodule
`default_nettype wire

// ===== hdl/wah_ctrl.sv =====
// Sequencer that steps the datapath through write, scan and range update.
`default_nettype none
module wah_ctrl import wah_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_MID   = 4'd4;
  localparam logic [3:0] S_DIV1  = 4'd5;
  localparam logic [3:0] S_PAD   = 4'd6;
  localparam logic [3:0] S_DIV2  = 4'd7;
  localparam logic [3:0] S_THR   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write      = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_MID;
      end
      S_MID: begin
        cmd.calc_mid = 1'b1;
        state_next   = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_span = 1'b1;
        state_next   = S_PAD;
      end
      S_PAD: begin
        cmd.calc_pad = 1'b1;
        state_next   = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_prev = 1'b1;
        state_next   = S_THR;
      end
      S_THR: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/wah_dp.sv =====
// Datapath: sample window memory, min/max scan, range arithmetic and result register.
`default_nettype none
module wah_dp import wah_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_W-1:0]           cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] sample_a,
  input  wire logic signed [SAMPLE_W-1:0] sample_b,
  input  wire logic signed [SAMPLE_W-1:0] sample_c,
  input  wire dp_cmd_t                    cmd,
  output dp_status_t                      status,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic signed [OUT_W-1:0]         out_low,
  output logic signed [OUT_W-1:0]         out_high,
  output logic                            out_moved
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int WORD_W = 3 * SAMPLE_W;

  function automatic logic signed [SAMPLE_W-1:0] smin(input logic signed [SAMPLE_W-1:0] x,
                                                      input logic signed [SAMPLE_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] smax(input logic signed [SAMPLE_W-1:0] x,
                                                      input logic signed [SAMPLE_W-1:0] y);
    return (x > y) ? x : y;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [OUT_W+1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  // Window memory and its bookkeeping.
  logic [WORD_W-1:0] mem [WINDOW_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              rd_valid;
  logic [ADDR_W-1:0] write_slot;
  logic [ADDR_W-1:0] scan_addr;
  logic [CNT_W-1:0]  fill_count;

  // Captured item and running extremes.
  logic signed [SAMPLE_W-1:0] cap_a, cap_b, cap_c;
  logic signed [SAMPLE_W-1:0] acc_lo, acc_hi;
  logic signed [SAMPLE_W-1:0] rd_a, rd_b, rd_c;

  // Range arithmetic registers.
  logic [CFG_W-1:0]           half_floor;
  logic signed [OUT_W:0]      rng_lo, rng_hi;
  logic [SAMPLE_W-1:0]        width;
  logic [SAMPLE_W-1:0]        prev_half;
  logic [PROD_W-1:0]          prod;
  logic signed [OUT_W-1:0]    new_lo, new_hi;
  logic signed [OUT_W-1:0]    shown_low, shown_high;

  // Combinational helpers.
  logic signed [SAMPLE_W:0]   sum, sum_adj, span;
  logic signed [SAMPLE_W-1:0] mid;
  logic [CFG_W:0]             twice;
  logic                       narrow;
  logic signed [OUT_W:0]      mid18, half18;
  logic [SAMPLE_W-1:0]        mul_x;
  logic [QUOT_W-1:0]          quot, quot_min1;
  logic signed [OUT_W+1:0]    lo19, hi19, pad19;
  logic signed [OUT_W:0]      shown_span;
  logic signed [OUT_W:0]      d_lo, d_hi;
  logic [OUT_W:0]             a_lo, a_hi, thr18;
  logic                       moved;

  assign rd_a = rd_data[WORD_W-1 -: SAMPLE_W];
  assign rd_b = rd_data[2*SAMPLE_W-1 -: SAMPLE_W];
  assign rd_c = rd_data[SAMPLE_W-1:0];

  // Status back to the sequencer.
  assign status.scan_last = (CNT_W'(scan_addr) + CNT_W'(1)) == fill_count;
  assign status.out_free  = !out_valid || out_ready;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[write_slot] <= {cap_a, cap_b, cap_c};
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[scan_addr];
    end
  end

  // Window control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.write) begin
        write_slot <= (write_slot == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + ADDR_W'(1);
        if (fill_count != CNT_W'(WINDOW_DEPTH)) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (cmd.scan_start) begin
        scan_addr <= '0;
      end else if (cmd.scan_rd) begin
        scan_addr <= scan_addr + ADDR_W'(1);
      end
    end
  end

  // Capture the item and fold each stored triple into the extremes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap_a  <= sample_a;
      cap_b  <= sample_b;
      cap_c  <= sample_c;
      acc_lo <= smin(smin(sample_a, sample_b), sample_c);
      acc_hi <= smax(smax(sample_a, sample_b), sample_c);
    end else if (rd_valid) begin
      acc_lo <= smin(acc_lo, smin(smin(rd_a, rd_b), rd_c));
      acc_hi <= smax(acc_hi, smax(smax(rd_a, rd_b), rd_c));
    end
  end

  // Midpoint, span and the re-centered range when the span is too small.
  always_comb begin
    sum     = {acc_lo[SAMPLE_W-1], acc_lo} + {acc_hi[SAMPLE_W-1], acc_hi};
    sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
    mid     = sum_adj[SAMPLE_W:1];
    span    = {acc_hi[SAMPLE_W-1], acc_hi} - {acc_lo[SAMPLE_W-1], acc_lo};
    twice   = {half_floor, 1'b0};
    narrow  = span[SAMPLE_W-1:0] < SAMPLE_W'(twice);
    mid18   = {{(OUT_W+1-SAMPLE_W){mid[SAMPLE_W-1]}}, mid};
    half18  = {{(OUT_W+1-CFG_W){1'b0}}, half_floor};
  end

  // Shared divide-by-ten: one multiply by the reciprocal, registered.
  assign mul_x     = cmd.div_prev ? prev_half : width;
  assign quot      = prod[PROD_W-1:RECIP_SHIFT];
  assign quot_min1 = (quot == '0) ? QUOT_W'(1) : quot;

  // Padding and clamp.
  always_comb begin
    pad19 = {{(OUT_W+2-QUOT_W){1'b0}}, quot_min1};
    lo19  = {rng_lo[OUT_W], rng_lo} - pad19;
    hi19  = {rng_hi[OUT_W], rng_hi} + pad19;
    shown_span = {shown_high[OUT_W-1], shown_high} - {shown_low[OUT_W-1], shown_low};
  end

  // Hysteresis compare against the stored range.
  always_comb begin
    d_lo  = {new_lo[OUT_W-1], new_lo} - {shown_low[OUT_W-1], shown_low};
    d_hi  = {new_hi[OUT_W-1], new_hi} - {shown_high[OUT_W-1], shown_high};
    a_lo  = d_lo[OUT_W] ? 18'(-d_lo) : 18'(d_lo);
    a_hi  = d_hi[OUT_W] ? 18'(-d_hi) : 18'(d_hi);
    thr18 = {{(OUT_W+1-QUOT_W){1'b0}}, quot_min1};
    moved = (a_lo > thr18) || (a_hi > thr18);
  end

  // Arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.calc_mid) begin
      rng_lo <= narrow ? mid18 - half18 : {{(OUT_W+1-SAMPLE_W){acc_lo[SAMPLE_W-1]}}, acc_lo};
      rng_hi <= narrow ? mid18 + half18 : {{(OUT_W+1-SAMPLE_W){acc_hi[SAMPLE_W-1]}}, acc_hi};
      width  <= narrow ? SAMPLE_W'(twice) : span[SAMPLE_W-1:0];
    end
    if (cmd.div_span || cmd.div_prev) begin
      prod <= {{(PROD_W-SAMPLE_W){1'b0}}, mul_x} * PROD_W'(RECIP10);
    end
    if (cmd.calc_pad) begin
      new_lo    <= clamp_out(lo19);
      new_hi    <= clamp_out(hi19);
      // A stored span below one counts as zero; halving it feeds the divide by twenty.
      prev_half <= (shown_span < 18'sd1) ? '0 : shown_span[SAMPLE_W:1];
    end
  end

  // Configuration register, stored range and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_floor <= HALF_RESET;
      shown_low  <= SHOWN_LO_RST;
      shown_high <= SHOWN_HI_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_floor <= cfg_data;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (moved) begin
          shown_low  <= new_lo;
          shown_high <= new_hi;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_low   <= moved ? new_lo : shown_low;
      out_high  <= moved ? new_hi : shown_high;
      out_moved <= moved;
    end
  end

  // The fill count never passes the window depth.
  assert property (@(posedge clk) disable iff (rst) fill_count <= CNT_W'(WINDOW_DEPTH))
    else $error("window fill count beyond depth");

  // Every scan read stays within the filled part of the window.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.scan_rd |-> (CNT_W'(scan_addr) < fill_count))
    else $error("scan read of an unfilled slot");

  // The stored range always keeps its upper bound above its lower bound.
  assert property (@(posedge clk) disable iff (rst) shown_high > shown_low)
    else $error("stored range inverted");

  // A committed result is presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule
`default_nettype wire
